FILE: design/npcs_pkg.sv
package npcs_pkg;

  localparam int CHAN_W     = 8;
  localparam int NUM_CHANS  = 3;
  localparam int NUM_COLORS = 16;
  localparam int IDX_W      = $clog2(NUM_COLORS);
  localparam int LVL_W      = 2;
  localparam int NUM_LEVELS = 1 << LVL_W;
  localparam int SQ_W       = 2 * CHAN_W;
  localparam int DIST_W     = SQ_W + 2;

  // min tree widths
  localparam int L1_N = NUM_COLORS / 2;
  localparam int L2_N = NUM_COLORS / 4;
  localparam int L3_N = NUM_COLORS / 8;

  // channel slots in a palette word
  localparam int CH_RED   = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 2;

  typedef logic [CHAN_W-1:0] chan_t;
  typedef logic [SQ_W-1:0]   sq_t;
  typedef logic [DIST_W-1:0] dist_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [LVL_W-1:0]  lvl_t;

  // standard 16-color VGA palette: red 7:0, green 15:8, blue 23:16
  localparam logic [NUM_CHANS*CHAN_W-1:0] PALETTE [NUM_COLORS] = '{
    24'h000000, 24'hAA0000, 24'h00AA00, 24'hAAAA00,
    24'h0000AA, 24'hAA00AA, 24'h0055AA, 24'hAAAAAA,
    24'h555555, 24'hFF5555, 24'h55FF55, 24'hFFFF55,
    24'h5555FF, 24'hFF55FF, 24'h55FFFF, 24'hFFFFFF
  };

  // every palette channel is one of 00/55/AA/FF, so the top two bits name it
  function automatic lvl_t level_of(input chan_t v);
    return v[CHAN_W-1 -: LVL_W];
  endfunction

  function automatic chan_t level_value(input lvl_t c);
    return {(CHAN_W / LVL_W){c}};
  endfunction

endpackage

FILE: design/npcs_dist.sv
module npcs_dist (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  npcs_pkg::chan_t  pixel_red,
  input  npcs_pkg::chan_t  pixel_green,
  input  npcs_pkg::chan_t  pixel_blue,
  input  logic             dn_en,
  output logic             dist_valid,
  output npcs_pkg::dist_t  entry_dist [npcs_pkg::NUM_COLORS]
);

  npcs_pkg::chan_t pix [npcs_pkg::NUM_CHANS];
  npcs_pkg::sq_t   sq_next [npcs_pkg::NUM_CHANS][npcs_pkg::NUM_LEVELS];
  npcs_pkg::sq_t   sq      [npcs_pkg::NUM_CHANS][npcs_pkg::NUM_LEVELS];
  npcs_pkg::dist_t entry_dist_next [npcs_pkg::NUM_COLORS];

  logic v1;
  logic v2;
  logic en1;
  logic en2;

  assign pix[npcs_pkg::CH_RED]   = pixel_red;
  assign pix[npcs_pkg::CH_GREEN] = pixel_green;
  assign pix[npcs_pkg::CH_BLUE]  = pixel_blue;

  // stage 1: squared distance of each channel to each of the four levels
  for (genvar c = 0; c < npcs_pkg::NUM_CHANS; c++) begin : g_chan
    for (genvar l = 0; l < npcs_pkg::NUM_LEVELS; l++) begin : g_lvl
      localparam npcs_pkg::chan_t LV = npcs_pkg::level_value(npcs_pkg::lvl_t'(l));
      npcs_pkg::chan_t ad;
      assign ad = (pix[c] > LV) ? pix[c] - LV : LV - pix[c];
      assign sq_next[c][l] = npcs_pkg::sq_t'(ad) * npcs_pkg::sq_t'(ad);
    end
  end

  // stage 2: entry distance as a sum of three picked squares
  for (genvar i = 0; i < npcs_pkg::NUM_COLORS; i++) begin : g_entry
    localparam npcs_pkg::lvl_t LR =
      npcs_pkg::level_of(npcs_pkg::PALETTE[i][npcs_pkg::CH_RED*npcs_pkg::CHAN_W +:
                                              npcs_pkg::CHAN_W]);
    localparam npcs_pkg::lvl_t LG =
      npcs_pkg::level_of(npcs_pkg::PALETTE[i][npcs_pkg::CH_GREEN*npcs_pkg::CHAN_W +:
                                              npcs_pkg::CHAN_W]);
    localparam npcs_pkg::lvl_t LB =
      npcs_pkg::level_of(npcs_pkg::PALETTE[i][npcs_pkg::CH_BLUE*npcs_pkg::CHAN_W +:
                                              npcs_pkg::CHAN_W]);
    assign entry_dist_next[i] = npcs_pkg::dist_t'(sq[npcs_pkg::CH_RED][LR])
                              + npcs_pkg::dist_t'(sq[npcs_pkg::CH_GREEN][LG])
                              + npcs_pkg::dist_t'(sq[npcs_pkg::CH_BLUE][LB]);
  end

  // a stage moves when it is empty or the next one moves
  assign en2      = !v2 || dn_en;
  assign en1      = !v1 || en2;
  assign in_stall = !en1;
  assign dist_valid = v2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) sq <= sq_next;
    if (en2) entry_dist <= entry_dist_next;
  end

endmodule

FILE: design/nearest_palette_color_search.sv
// Nearest color search over the 16-color VGA palette.
// Input channel: in_valid / in_stall with pixel_red, pixel_green, pixel_blue.
// A pixel transfers on a clock edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall with color_index, the palette entry
// at the smallest squared RGB distance; the lowest index wins a tie.
// Four register stages lie between a pixel accepted on the input and
// out_valid: channel squares, entry sums, two min-tree halves.
// Throughput: one pixel per clock while out_stall stays low, limited by
// no shared unit; every stage holds its own pixel.
// Reset (rst, synchronous) empties all stages; payload is not cleared.
// When the receiver stalls, the output register holds its result and the
// stages behind it keep filling bubbles; in_stall rises only once all four
// stages hold pixels, so nothing is dropped or repeated.
module nearest_palette_color_search (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  npcs_pkg::chan_t  pixel_red,
  input  npcs_pkg::chan_t  pixel_green,
  input  npcs_pkg::chan_t  pixel_blue,
  output logic             out_valid,
  input  logic             out_stall,
  output npcs_pkg::idx_t   color_index
);

  logic            dist_valid;
  npcs_pkg::dist_t entry_dist [npcs_pkg::NUM_COLORS];

  logic v3;
  logic en3;
  logic en4;

  // first min-tree half: 16 -> 8 -> 4, registered
  npcs_pkg::dist_t l1_d [npcs_pkg::L1_N];
  npcs_pkg::idx_t  l1_i [npcs_pkg::L1_N];
  npcs_pkg::dist_t m3_d_next [npcs_pkg::L2_N];
  npcs_pkg::idx_t  m3_i_next [npcs_pkg::L2_N];
  npcs_pkg::dist_t m3_d [npcs_pkg::L2_N];
  npcs_pkg::idx_t  m3_i [npcs_pkg::L2_N];

  // second half: 4 -> 2 -> 1
  npcs_pkg::dist_t l3_d [npcs_pkg::L3_N];
  npcs_pkg::idx_t  l3_i [npcs_pkg::L3_N];
  npcs_pkg::idx_t  color_index_next;

  npcs_dist u_dist (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .pixel_red  (pixel_red),
    .pixel_green(pixel_green),
    .pixel_blue (pixel_blue),
    .dn_en      (en3),
    .dist_valid (dist_valid),
    .entry_dist (entry_dist)
  );

  // each compare keeps the left (lower index) entry unless the right is
  // strictly closer, which gives lowest-index-wins across the whole tree
  always_comb begin
    for (int k = 0; k < npcs_pkg::L1_N; k++) begin
      if (entry_dist[2*k+1] < entry_dist[2*k]) begin
        l1_d[k] = entry_dist[2*k+1];
        l1_i[k] = npcs_pkg::idx_t'(2*k+1);
      end else begin
        l1_d[k] = entry_dist[2*k];
        l1_i[k] = npcs_pkg::idx_t'(2*k);
      end
    end
    for (int k = 0; k < npcs_pkg::L2_N; k++) begin
      if (l1_d[2*k+1] < l1_d[2*k]) begin
        m3_d_next[k] = l1_d[2*k+1];
        m3_i_next[k] = l1_i[2*k+1];
      end else begin
        m3_d_next[k] = l1_d[2*k];
        m3_i_next[k] = l1_i[2*k];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < npcs_pkg::L3_N; k++) begin
      if (m3_d[2*k+1] < m3_d[2*k]) begin
        l3_d[k] = m3_d[2*k+1];
        l3_i[k] = m3_i[2*k+1];
      end else begin
        l3_d[k] = m3_d[2*k];
        l3_i[k] = m3_i[2*k];
      end
    end
    if (l3_d[1] < l3_d[0]) begin
      color_index_next = l3_i[1];
    end else begin
      color_index_next = l3_i[0];
    end
  end

  // output register frees when empty or taken
  assign en4 = !out_valid || !out_stall;
  assign en3 = !v3 || en4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en3) v3 <= dist_valid;
      if (en4) out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      m3_d <= m3_d_next;
      m3_i <= m3_i_next;
    end
    if (en4) color_index <= color_index_next;
  end

  // a free-running output drains an accepted pixel through to out_valid
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) ##1 !out_stall ##1 !out_stall ##1 !out_stall
      |=> out_valid)
    else $error("accepted pixel did not reach the output in four cycles");

  // back-pressure reaches the input only when every stage is full
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall && v3 && dist_valid))
    else $error("input stalled while the pipeline has room");

  // stage three fills only from a valid distance stage
  a_v3_src: assert property (@(posedge clk) disable iff (rst)
    $rose(v3) |-> $past(dist_valid))
    else $error("stage three became valid without a source");

  // the output becomes valid only from a valid stage three
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(v3))
    else $error("output became valid without a source");

endmodule

FILE: tb/nearest_palette_color_search_tb.sv
module nearest_palette_color_search_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Cycles with no transfer on either side before the run is declared hung.
  localparam int HANG_LIMIT   = 2000;
  // Pipeline depth is four stages; the tail watch is longer than the pipe.
  localparam int TAIL_CYCLES  = 12;
  localparam int RANDOM_ITEMS = 830;
  // The last stretch of random pixels runs with neither side idling.
  localparam int QUIET_ITEMS  = 150;
  // Pixel count at which the sender holds off until the pipe is drained.
  localparam int DRAIN_AT     = 400;

  // VGA palette as 24-bit words: red 7:0, green 15:8, blue 23:16.
  localparam bit [23:0] VGA_WORDS [0:15] = '{
    24'h000000, 24'hAA0000, 24'h00AA00, 24'hAAAA00,
    24'h0000AA, 24'hAA00AA, 24'h0055AA, 24'hAAAAAA,
    24'h555555, 24'hFF5555, 24'h55FF55, 24'hFFFF55,
    24'h5555FF, 24'hFF55FF, 24'h55FFFF, 24'hFFFFFF
  };

  // Directed table: {want, red, green, blue}. A want of PREDICT means the
  // expected index comes from the distance search below.
  localparam bit [7:0] PREDICT  = 8'hFF;
  localparam int       DIR_ROWS = 24;
  localparam bit [31:0] DIRECTED_ROWS [0:DIR_ROWS-1] = '{
    // exact hits on every palette entry, in index order
    {8'd0,  8'h00, 8'h00, 8'h00},
    {8'd1,  8'h00, 8'h00, 8'hAA},
    {8'd2,  8'h00, 8'hAA, 8'h00},
    {8'd3,  8'h00, 8'hAA, 8'hAA},
    {8'd4,  8'hAA, 8'h00, 8'h00},
    {8'd5,  8'hAA, 8'h00, 8'hAA},
    {8'd6,  8'hAA, 8'h55, 8'h00},
    {8'd7,  8'hAA, 8'hAA, 8'hAA},
    {8'd8,  8'h55, 8'h55, 8'h55},
    {8'd9,  8'h55, 8'h55, 8'hFF},
    {8'd10, 8'h55, 8'hFF, 8'h55},
    {8'd11, 8'h55, 8'hFF, 8'hFF},
    {8'd12, 8'hFF, 8'h55, 8'h55},
    {8'd13, 8'hFF, 8'h55, 8'hFF},
    {8'd14, 8'hFF, 8'hFF, 8'h55},
    {8'd15, 8'hFF, 8'hFF, 8'hFF},
    // blue term must compare blue with blue: pure blue vs pure red
    {PREDICT, 8'h00, 8'h00, 8'hFF},
    {PREDICT, 8'hFF, 8'h00, 8'h00},
    // halfway between black and blue: equal distance, lower index wins
    {PREDICT, 8'h00, 8'h00, 8'h55},
    // halfway between black and green, and a point equidistant from entries 0, 1, 4, 5
    {PREDICT, 8'h00, 8'h55, 8'h00},
    {PREDICT, 8'h55, 8'h00, 8'h55},
    // mid-gray and near-extremes
    {PREDICT, 8'h80, 8'h80, 8'h80},
    {PREDICT, 8'h7F, 8'h7F, 8'h7F},
    {PREDICT, 8'h01, 8'hFE, 8'h02}
  };

  typedef struct packed {
    npcs_pkg::chan_t red;
    npcs_pkg::chan_t green;
    npcs_pkg::chan_t blue;
    npcs_pkg::idx_t  idx;
  } pending_t;

  logic            clk = 1'b0;
  logic            rst;
  logic            in_valid;
  logic            in_stall;
  npcs_pkg::chan_t pixel_red;
  npcs_pkg::chan_t pixel_green;
  npcs_pkg::chan_t pixel_blue;
  logic            out_valid;
  logic            out_stall;
  npcs_pkg::idx_t  color_index;

  // Indexes still owed by the block, oldest first, with the pixel for logs.
  pending_t pending_idx_q[$];
  int       mismatches = 0;
  int       hang_cycles = 0;
  int       stall_left = 0;
  bit       quiet = 1'b0;

  nearest_palette_color_search dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .pixel_red   (pixel_red),
    .pixel_green (pixel_green),
    .pixel_blue  (pixel_blue),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .color_index (color_index)
  );

  always #4 clk = ~clk;

  // Smallest squared RGB distance over the palette; strict less-than keeps
  // the lowest index on a tie, and an exact hit lands on its first entry.
  function automatic npcs_pkg::idx_t nearest_vga_index(npcs_pkg::chan_t r,
                                                       npcs_pkg::chan_t g,
                                                       npcs_pkg::chan_t b);
    int             best_dist;
    int             cur_dist;
    int             dr;
    int             dg;
    int             db;
    npcs_pkg::idx_t best;
    best_dist = 0;
    best = '0;
    for (int i = 0; i < 16; i++) begin
      dr = int'(VGA_WORDS[i][7:0]) - int'(r);
      dg = int'(VGA_WORDS[i][15:8]) - int'(g);
      db = int'(VGA_WORDS[i][23:16]) - int'(b);
      cur_dist = dr * dr + dg * dg + db * db;
      if (i == 0 || cur_dist < best_dist) begin
        best_dist = cur_dist;
        best = npcs_pkg::idx_t'(i);
      end
    end
    return best;
  endfunction

  task automatic note_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch @%0t: %s", $realtime, msg);
  endtask

  // Present one pixel at the falling edge and hold it until it transfers.
  // The expectation is queued at the accepting edge.
  task automatic send_pixel(npcs_pkg::chan_t r, npcs_pkg::chan_t g,
                            npcs_pkg::chan_t b, npcs_pkg::idx_t want);
    pending_t p;
    @(negedge clk);
    in_valid = 1'b1;
    pixel_red = r;
    pixel_green = g;
    pixel_blue = b;
    do @(posedge clk); while (in_stall);
    p.red = r;
    p.green = g;
    p.blue = b;
    p.idx = want;
    pending_idx_q.push_back(p);
  endtask

  // Valid low for the requested idle stretch; payload gets noise since nobody should look at it.
  task automatic idle_input(int n);
    repeat (n) begin
      @(negedge clk);
      in_valid = 1'b0;
      pixel_red = npcs_pkg::chan_t'($urandom);
      pixel_green = npcs_pkg::chan_t'($urandom);
      pixel_blue = npcs_pkg::chan_t'($urandom);
    end
  endtask

  // Hold the sender off until every owed index has come out.
  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_idx_q.size() != 0) @(posedge clk);
  endtask

  // Random pixel, shaped so that most land near the palette grid or on the
  // midpoints between levels, where ties and close calls live.
  task automatic random_pixel(output npcs_pkg::chan_t r, output npcs_pkg::chan_t g,
                              output npcs_pkg::chan_t b);
    int              kind;
    int              e;
    int              f;
    int              v;
    npcs_pkg::chan_t ch [3];
    kind = $urandom_range(0, 9);
    e = $urandom_range(0, 15);
    f = $urandom_range(0, 15);
    for (int c = 0; c < 3; c++) begin
      case (kind)
        0, 1, 2, 3: begin
          ch[c] = npcs_pkg::chan_t'($urandom);
        end
        4, 5, 6: begin
          // palette entry with a small jitter, clamped into range
          v = int'(VGA_WORDS[e][8*c +: 8]) + $urandom_range(0, 48) - 24;
          if (v < 0) v = 0;
          if (v > 255) v = 255;
          ch[c] = npcs_pkg::chan_t'(v);
        end
        7, 8: begin
          // midpoint of two entries on this axis, rounded down, nudged up by zero or one
          v = (int'(VGA_WORDS[e][8*c +: 8]) + int'(VGA_WORDS[f][8*c +: 8])) / 2;
          ch[c] = npcs_pkg::chan_t'(v + $urandom_range(0, 1));
        end
        default: begin
          case ($urandom_range(0, 7))
            0: ch[c] = 8'h00;
            1: ch[c] = 8'h55;
            2: ch[c] = 8'hAA;
            3: ch[c] = 8'hFF;
            4: ch[c] = 8'h7F;
            5: ch[c] = 8'h80;
            6: ch[c] = 8'h01;
            default: ch[c] = 8'hFE;
          endcase
        end
      endcase
    end
    r = ch[0];
    g = ch[1];
    b = ch[2];
  endtask

  // Receiver: random stall bursts, changed at the falling edge,
  // one assignment per edge. No new burst starts once the quiet stretch begins.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_stall = 1'b1;
        stall_left--;
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
        out_stall = 1'b1;
        stall_left = $urandom_range(1, 16) - 1;
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  // Scoreboard: every transfer on the output is checked against the oldest
  // owed index. Sampled at the rising edge, before the block's own updates.
  always @(posedge clk) begin
    pending_t p;
    if (!rst && out_valid && !out_stall) begin
      if (pending_idx_q.size() == 0) begin
        note_mismatch($sformatf("color_index %0d with no pixel pending", color_index));
      end else begin
        p = pending_idx_q.pop_front();
        if (color_index !== p.idx)
          note_mismatch($sformatf("pixel r=%02h g=%02h b=%02h: color_index exp %0d got %0d",
                                  p.red, p.green, p.blue, p.idx, color_index));
      end
    end
  end

  // Watchdog: counts edges with no transfer on either channel.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      hang_cycles <= 0;
    end else if (hang_cycles >= HANG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      hang_cycles <= hang_cycles + 1;
    end
  end

  initial begin
    npcs_pkg::chan_t r;
    npcs_pkg::chan_t g;
    npcs_pkg::chan_t b;
    npcs_pkg::idx_t  want;
    rst = 1'b1;
    in_valid = 1'b0;
    pixel_red = '0;
    pixel_green = '0;
    pixel_blue = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed table: palette hits, blue-vs-red, ties and near-extremes.
    for (int i = 0; i < DIR_ROWS; i++) begin
      r = DIRECTED_ROWS[i][23:16];
      g = DIRECTED_ROWS[i][15:8];
      b = DIRECTED_ROWS[i][7:0];
      if (DIRECTED_ROWS[i][31:24] == PREDICT) want = nearest_vga_index(r, g, b);
      else want = npcs_pkg::idx_t'(DIRECTED_ROWS[i][31:24]);
      send_pixel(r, g, b, want);
      if ($urandom_range(0, 5) == 0) idle_input($urandom_range(1, 16));
    end
    drain_results();

    // Random stream; sender gaps come in bursts, none in the last stretch.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
      if (n == DRAIN_AT) drain_results();
      random_pixel(r, g, b);
      send_pixel(r, g, b, nearest_vga_index(r, g, b));
      if (!quiet && $urandom_range(0, 7) == 0) idle_input($urandom_range(1, 16));
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (pending_idx_q.size() != 0) @(posedge clk);
    // Keep watching for stray outputs past the last owed index.
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0 && pending_idx_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
